/* rtl/core/multilevel_priority_task_picker_macros.svh */
// assertion macros for the multilevel priority task picker
`ifndef MULTILEVEL_PRIORITY_TASK_PICKER_MACROS_SVH
`define MULTILEVEL_PRIORITY_TASK_PICKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MLPT_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mlpt assertion failed");
// next-cycle implication
`define MLPT_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mlpt assertion failed");
`else
`define MLPT_ASSERT_NOW(name, clk, rst, pre, post)
`define MLPT_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

/* rtl/core/mlpt_pkg.sv */
// shared types, codes and constants of the multilevel priority task picker
package mlpt_pkg;

   // sizes
   localparam int TASK_COUNT_DEF = 64;
   localparam int STATUS_W       = 2;
   localparam int LEVEL_W        = 4;
   localparam int RUNS_W         = 8;
   localparam int IRQ_W          = 8;
   localparam int MODE_W         = 2;
   localparam int TIDX_W         = 6;
   localparam int OUTC_W         = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 8;

   // saturation limits
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [RUNS_W-1:0]  RUNS_MAX  = '1;
   localparam logic [IRQ_W-1:0]   IRQ_MAX   = '1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_SET_STATUS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TIMER_TICK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_YIELD      = 2'd2;

   // task status codes
   localparam logic [STATUS_W-1:0] ST_NOT_RUNNABLE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUNNABLE     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RUNNING      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DYING        = 2'd3;

   // response outcomes
   localparam logic [OUTC_W-1:0] OUT_ACK  = 2'd0;
   localparam logic [OUTC_W-1:0] OUT_PICK = 2'd1;
   localparam logic [OUTC_W-1:0] OUT_HALT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUNS_PER_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_BOOST_LIMIT = 2'd3;

   // register reset values
   localparam logic               POLICY_RST    = 1'b1;
   localparam logic [RUNS_W-1:0]  RUNS_RST      = 8'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_CNT_RST = 4'd7;
   localparam logic [IRQ_W-1:0]   IRQ_LIM_RST   = 8'd6;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [TIDX_W-1:0]   task_index;
      logic [STATUS_W-1:0] new_status;
   } req_type;

   typedef struct packed {
      logic [OUTC_W-1:0] outcome;
      logic [TIDX_W-1:0] picked_task;
      logic              boosted;
   } rsp_type;

   // write side of the task table
   typedef struct packed {
      logic                st_we;
      logic                sc_we;
      logic [STATUS_W-1:0] st_wdata;
      logic [LEVEL_W-1:0]  sc_level;
      logic [RUNS_W-1:0]   sc_count;
   } mem_wr_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_BOOST,
      S_CUR_RD,
      S_CUR_CAP,
      S_SCAN,
      S_DECIDE,
      S_RUN_RD,
      S_RUN_WR,
      S_RESP
   } pick_state_type;

endpackage

/* rtl/core/mlpt_task_mem.sv */
// task table: status memory and level / run count memory, one read and one write port
module mlpt_task_mem
   import mlpt_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic                        clock,
   input  logic [$clog2(TASK_COUNT)-1:0] raddr,
   input  logic [$clog2(TASK_COUNT)-1:0] waddr,
   input  mem_wr_type                  wr,
   output logic [STATUS_W-1:0]         st_rdata,
   output logic [LEVEL_W-1:0]          lvl_rdata,
   output logic [RUNS_W-1:0]           cnt_rdata
);

   localparam int SC_W = LEVEL_W + RUNS_W;

   logic [STATUS_W-1:0] st_mem [TASK_COUNT];
   logic [SC_W-1:0]     sc_mem [TASK_COUNT];
   logic [STATUS_W-1:0] st_rdata_ff;
   logic [SC_W-1:0]     sc_rdata_ff;

   // status memory
   always_ff @(posedge clock) begin
      if (wr.st_we) begin
         st_mem[waddr] <= wr.st_wdata;
      end
      st_rdata_ff <= st_mem[raddr];
   end

   // level and run count memory
   always_ff @(posedge clock) begin
      if (wr.sc_we) begin
         sc_mem[waddr] <= {wr.sc_level, wr.sc_count};
      end
      sc_rdata_ff <= sc_mem[raddr];
   end

   assign st_rdata  = st_rdata_ff;
   assign lvl_rdata = sc_rdata_ff[SC_W-1:RUNS_W];
   assign cnt_rdata = sc_rdata_ff[RUNS_W-1:0];

endmodule

/* rtl/core/multilevel_priority_task_picker.sv */
// multilevel priority task picker top level: sequencer, circular scan and response register
//
//   channel  ports                          direction  moves
//   req      req_valid req_ready req_data   in         set status, timer tick, yield
//   rsp      rsp_valid rsp_ready rsp_data   out        outcome, picked task, boost flag
//   csr      csr_we csr_index csr_wdata     in         policy and limit registers
//
// set status, timer tick and unused mode: S_EXEC goes straight to S_RESP, then back to S_IDLE
// a yield fetches the current entry, scans the table at one table read per cycle, then picks or halts
// each global boost adds a sweep over every entry of the level and run count memory (at most two per yield)
// after reset a clearing pass over every table entry runs with req_ready low
// a new request is taken while the previous response still waits; the sequencer
// only stalls in its final step until the response register is free
`include "multilevel_priority_task_picker_macros.svh"

module multilevel_priority_task_picker
   import mlpt_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(TASK_COUNT);
   localparam int CNT_W = $clog2(TASK_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);
   localparam logic [CNT_W-1:0] SCAN_LEN = CNT_W'(TASK_COUNT);

   pick_state_type state_ff, state_in;

   // configuration
   logic               policy_ff, policy_in;
   logic [RUNS_W-1:0]  rpl_ff, rpl_in;
   logic [LEVEL_W-1:0] lvlcnt_ff, lvlcnt_in;
   logic [IRQ_W-1:0]   irqlim_ff, irqlim_in;

   // scheduler state
   logic [IRQ_W-1:0]   irq_cnt_ff, irq_cnt_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]   cur_task_ff, cur_task_in;
   logic [STATUS_W-1:0] cur_state_ff, cur_state_in;
   logic [LEVEL_W-1:0] cur_level_ff, cur_level_in;
   logic [RUNS_W-1:0]  cur_count_ff, cur_count_in;

   // request and sweep / scan control
   req_type            req_ff, req_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               fnd_bnd_ff, fnd_bnd_in;
   logic [IDX_W-1:0]   bnd_idx_ff, bnd_idx_in;
   logic               fnd_any_ff, fnd_any_in;
   logic [IDX_W-1:0]   any_idx_ff, any_idx_in;
   logic               boost_ret_ff, boost_ret_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;

   // result
   logic [OUTC_W-1:0]  res_outcome_ff, res_outcome_in;
   logic               res_boosted_ff, res_boosted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // table port
   logic [IDX_W-1:0]    mem_raddr;
   logic [IDX_W-1:0]    mem_waddr;
   mem_wr_type          mem_wr;
   logic [STATUS_W-1:0] mem_st;
   logic [LEVEL_W-1:0]  mem_lvl;
   logic [RUNS_W-1:0]   mem_cnt;

   // pick decision
   logic               pick_found;
   logic [IDX_W-1:0]   pick_idx;
   logic               charge;
   logic [LEVEL_W-1:0] new_level;
   logic [IDX_W-1:0]   scan_start;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
      if (a == LAST_IDX) begin
         wrap_inc = '0;
      end else begin
         wrap_inc = a + 1'b1;
      end
   endfunction

   mlpt_task_mem #(
      .TASK_COUNT(TASK_COUNT)
   ) u_task_mem (
      .clock     (clock),
      .raddr     (mem_raddr),
      .waddr     (mem_waddr),
      .wr        (mem_wr),
      .st_rdata  (mem_st),
      .lvl_rdata (mem_lvl),
      .cnt_rdata (mem_cnt)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         policy_ff    <= POLICY_RST;
         rpl_ff       <= RUNS_RST;
         lvlcnt_ff    <= LEVEL_CNT_RST;
         irqlim_ff    <= IRQ_LIM_RST;
         irq_cnt_ff   <= '0;
         cur_valid_ff <= 1'b0;
         cur_task_ff  <= '0;
         addr_ff      <= '0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         fnd_bnd_ff   <= 1'b0;
         fnd_any_ff   <= 1'b0;
         boost_ret_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         rpl_ff       <= rpl_in;
         lvlcnt_ff    <= lvlcnt_in;
         irqlim_ff    <= irqlim_in;
         irq_cnt_ff   <= irq_cnt_in;
         cur_valid_ff <= cur_valid_in;
         cur_task_ff  <= cur_task_in;
         addr_ff      <= addr_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         fnd_bnd_ff   <= fnd_bnd_in;
         fnd_any_ff   <= fnd_any_in;
         boost_ret_ff <= boost_ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      cur_state_ff   <= cur_state_in;
      cur_level_ff   <= cur_level_in;
      cur_count_ff   <= cur_count_in;
      rd_idx_ff      <= rd_idx_in;
      bnd_idx_ff     <= bnd_idx_in;
      any_idx_ff     <= any_idx_in;
      pick_ff        <= pick_in;
      res_outcome_ff <= res_outcome_in;
      res_boosted_ff <= res_boosted_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // configuration writes
   always_comb begin
      policy_in = policy_ff;
      rpl_in    = rpl_ff;
      lvlcnt_in = lvlcnt_ff;
      irqlim_in = irqlim_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY_MODE:     policy_in = csr_wdata[0];
            CSR_RUNS_PER_LEVEL:  rpl_in    = csr_wdata[RUNS_W-1:0];
            CSR_LEVEL_COUNT:     lvlcnt_in = csr_wdata[LEVEL_W-1:0];
            CSR_IRQ_BOOST_LIMIT: irqlim_in = csr_wdata[IRQ_W-1:0];
            default:             policy_in = policy_ff;
         endcase
      end
   end

   // pick order, policy set: bounded hit, current if running, any hit; else any hit, current if running
   always_comb begin
      pick_found = 1'b1;
      pick_idx   = bnd_idx_ff;
      if (policy_ff && fnd_bnd_ff) begin
         pick_idx = bnd_idx_ff;
      end else if (!policy_ff && fnd_any_ff) begin
         pick_idx = any_idx_ff;
      end else if (cur_valid_ff && (cur_state_ff == ST_RUNNING)) begin
         pick_idx = cur_task_ff;
      end else if (policy_ff && fnd_any_ff) begin
         pick_idx = any_idx_ff;
      end else begin
         pick_found = 1'b0;
      end
   end

   // level drop of the yielding task
   assign charge    = policy_ff && cur_valid_ff && (cur_count_ff >= rpl_ff);
   assign new_level = (cur_level_ff == LEVEL_MAX) ? LEVEL_MAX : cur_level_ff + 1'b1;

   // circular scan start
   always_comb begin
      if (cur_valid_ff) begin
         scan_start = wrap_inc(cur_task_ff);
      end else if (policy_ff) begin
         scan_start = IDX_W'(1);
      end else begin
         scan_start = '0;
      end
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in       = state_ff;
      irq_cnt_in     = irq_cnt_ff;
      cur_valid_in   = cur_valid_ff;
      cur_task_in    = cur_task_ff;
      cur_state_in   = cur_state_ff;
      cur_level_in   = cur_level_ff;
      cur_count_in   = cur_count_ff;
      req_in         = req_ff;
      addr_in        = addr_ff;
      issue_cnt_in   = issue_cnt_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      fnd_bnd_in     = fnd_bnd_ff;
      bnd_idx_in     = bnd_idx_ff;
      fnd_any_in     = fnd_any_ff;
      any_idx_in     = any_idx_ff;
      boost_ret_in   = boost_ret_ff;
      pick_in        = pick_ff;
      res_outcome_in = res_outcome_ff;
      res_boosted_in = res_boosted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      req_ready      = 1'b0;
      mem_raddr      = addr_ff;
      mem_waddr      = addr_ff;
      mem_wr         = '0;

      unique case (state_ff)
         // clear the whole table after reset
         S_CLEAR: begin
            mem_wr.st_we = 1'b1;
            mem_wr.sc_we = 1'b1;
            addr_in      = wrap_inc(addr_ff);
            if (addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         // take a request
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end

         // dispatch by mode
         S_EXEC: begin
            res_outcome_in = OUT_ACK;
            res_boosted_in = 1'b0;
            state_in       = S_RESP;
            case (req_ff.mode)
               MODE_SET_STATUS: begin
                  if (32'(req_ff.task_index) < TASK_COUNT) begin
                     mem_waddr       = IDX_W'(req_ff.task_index);
                     mem_wr.st_we    = 1'b1;
                     mem_wr.st_wdata = req_ff.new_status;
                  end
               end
               MODE_TIMER_TICK: begin
                  if (irq_cnt_ff != IRQ_MAX) begin
                     irq_cnt_in = irq_cnt_ff + 1'b1;
                  end
               end
               MODE_YIELD: begin
                  if (irq_cnt_ff > irqlim_ff) begin
                     irq_cnt_in     = '0;
                     res_boosted_in = 1'b1;
                     boost_ret_in   = 1'b0;
                     addr_in        = '0;
                     state_in       = S_BOOST;
                  end else begin
                     state_in = S_CUR_RD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // global boost: zero every level and run count
         S_BOOST: begin
            mem_wr.sc_we = 1'b1;
            addr_in      = wrap_inc(addr_ff);
            if (addr_ff == LAST_IDX) begin
               state_in = boost_ret_ff ? S_RUN_RD : S_CUR_RD;
            end
         end

         // fetch the current task entry
         S_CUR_RD: begin
            mem_raddr = cur_task_ff;
            state_in  = S_CUR_CAP;
         end

         S_CUR_CAP: begin
            cur_state_in = mem_st;
            cur_level_in = cur_valid_ff ? mem_lvl : '0;
            cur_count_in = mem_cnt;
            addr_in      = scan_start;
            issue_cnt_in = '0;
            fnd_bnd_in   = 1'b0;
            fnd_any_in   = 1'b0;
            state_in     = S_SCAN;
         end

         // one table read per cycle, compared in the cycle after the read
         S_SCAN: begin
            if (issue_cnt_ff != SCAN_LEN) begin
               mem_raddr    = addr_ff;
               rd_vld_in    = 1'b1;
               rd_idx_in    = addr_ff;
               addr_in      = wrap_inc(addr_ff);
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (rd_vld_ff && (mem_st == ST_RUNNABLE)) begin
               if (!fnd_any_ff) begin
                  fnd_any_in = 1'b1;
                  any_idx_in = rd_idx_ff;
               end
               if (!fnd_bnd_ff && (mem_lvl <= cur_level_ff)) begin
                  fnd_bnd_in = 1'b1;
                  bnd_idx_in = rd_idx_ff;
               end
            end
            if ((issue_cnt_ff == SCAN_LEN) && !rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end

         // choose, charge the yielding task, or halt
         S_DECIDE: begin
            if (!pick_found) begin
               cur_valid_in   = 1'b0;
               res_outcome_in = OUT_HALT;
               state_in       = S_RESP;
            end else begin
               pick_in        = pick_idx;
               res_outcome_in = OUT_PICK;
               state_in       = S_RUN_RD;
               if (charge) begin
                  mem_waddr       = cur_task_ff;
                  mem_wr.sc_we    = 1'b1;
                  mem_wr.sc_level = new_level;
                  mem_wr.sc_count = '0;
                  if (new_level >= lvlcnt_ff) begin
                     res_boosted_in = 1'b1;
                     boost_ret_in   = 1'b1;
                     addr_in        = '0;
                     state_in       = S_BOOST;
                  end
               end
            end
         end

         // read the picked entry, demote the old running task
         S_RUN_RD: begin
            mem_raddr = pick_ff;
            if (cur_valid_ff && (cur_state_ff == ST_RUNNING)) begin
               mem_waddr       = cur_task_ff;
               mem_wr.st_we    = 1'b1;
               mem_wr.st_wdata = ST_RUNNABLE;
            end
            state_in = S_RUN_WR;
         end

         // mark picked task running and count one run
         S_RUN_WR: begin
            mem_waddr       = pick_ff;
            mem_wr.st_we    = 1'b1;
            mem_wr.st_wdata = ST_RUNNING;
            mem_wr.sc_we    = 1'b1;
            mem_wr.sc_level = mem_lvl;
            mem_wr.sc_count = (mem_cnt == RUNS_MAX) ? RUNS_MAX : mem_cnt + 1'b1;
            cur_task_in     = pick_ff;
            cur_valid_in    = 1'b1;
            state_in        = S_RESP;
         end

         // hand the result to the response register
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.outcome     = res_outcome_ff;
               rsp_data_in.picked_task = (res_outcome_ff == OUT_PICK) ? TIDX_W'(pick_ff) : '0;
               rsp_data_in.boosted     = res_boosted_ff;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `MLPT_ASSERT_NEXT(a_run_sets_current, clock, reset, state_ff == S_RUN_WR, cur_valid_ff)
   `MLPT_ASSERT_NEXT(a_halt_clears_current, clock, reset,
      (state_ff == S_DECIDE) && !pick_found, !cur_valid_ff)
   `MLPT_ASSERT_NOW(a_ack_has_no_pick, clock, reset,
      rsp_valid_ff && (rsp_data_ff.outcome == OUT_ACK),
      (rsp_data_ff.picked_task == '0) && !rsp_data_ff.boosted)
   `MLPT_ASSERT_NOW(a_scan_bounded, clock, reset, state_ff == S_SCAN, issue_cnt_ff <= SCAN_LEN)

endmodule
